// ===== sv/qot_pkg.sv =====
// Package for the quadrature odometry tracker: shared types, constants and tables.
// No dependencies.
`default_nettype none
package qot_pkg;

    localparam int unsigned CordicIterationsDefault = 24;
    localparam logic signed [63:0] PiQ      = 64'sd1686629713;
    localparam logic signed [63:0] TwoPiQ   = 64'sd3373259426;
    localparam logic signed [63:0] HalfPiQ  = 64'sd843314857;
    localparam logic signed [63:0] CordicGain = 64'sd652032874;
    localparam logic [63:0] Sign64 = 64'h8000_0000_0000_0000;

    // register indexes
    localparam logic [2:0] RegRightDpc   = 3'd0;
    localparam logic [2:0] RegLeftDpc    = 3'd1;
    localparam logic [2:0] RegInvWb      = 3'd2;
    localparam logic [2:0] RegSpeedPer   = 3'd3;
    localparam logic [2:0] RegSpeedScale = 3'd4;

    localparam logic OpEdge = 1'b0;
    localparam logic OpTick = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_R, ST_MUL_L, ST_CENTER, ST_MUL_TH, ST_HEAD,
        ST_CORDIC, ST_MUL_X, ST_MUL_Y, ST_MUL_SR, ST_MUL_SL, ST_MUL_ST, ST_OUT
    } state_t;

    // b is a 33-bit signed operand: unsigned 32-bit registers carry a zero sign bit
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [32:0] b;
        logic [5:0]  shift;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } mul_rsp_t;

    function automatic logic signed [63:0] atan_entry(input logic [4:0] i);
        logic signed [63:0] r;
        begin
            case (i)
                5'd0: r = 64'sd421657428;
                5'd1: r = 64'sd248918915;
                5'd2: r = 64'sd131521918;
                5'd3: r = 64'sd66762579;
                5'd4: r = 64'sd33510843;
                5'd5: r = 64'sd16771758;
                5'd6: r = 64'sd8387925;
                5'd7: r = 64'sd4194219;
                5'd8: r = 64'sd2097141;
                5'd9: r = 64'sd1048575;
                5'd30, 5'd31: r = 64'sd0;
                default: r = 64'sd1 <<< (5'd29 - i);
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/qot_if.sv =====
// Valid/ready channel interfaces for the odometry tracker input and result.
// Depends on nothing.
`default_nettype none
interface qot_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic wheel;
    logic channel;
    logic level_a;
    logic level_b;
    modport source (output valid, opcode, wheel, channel, level_a, level_b, input ready);
    modport sink (input valid, opcode, wheel, channel, level_a, level_b, output ready);
endinterface

interface qot_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] pos_x;
    logic [63:0] pos_y;
    logic [31:0] heading;
    logic [63:0] center_distance;
    logic [63:0] right_speed;
    logic [63:0] left_speed;
    logic [63:0] turn_speed;
    logic        speed_valid;
    modport source (output valid, pos_x, pos_y, heading, center_distance, right_speed,
                    left_speed, turn_speed, speed_valid, input ready);
    modport sink (input valid, pos_x, pos_y, heading, center_distance, right_speed,
                  left_speed, turn_speed, speed_valid, output ready);
endinterface
`default_nettype wire

// ===== sv/quadrature_odometry_tracker.sv =====
// Top level of the quadrature odometry tracker: sequencer, state, APB registers.
// Depends on qot_pkg, qot_if and qot_serial_mul.
// Encoder edge: accepted in the idle state, no result.
// Update tick: five products in the shared multiplier and CORDIC_ITERATIONS CORDIC steps to the result,
// three more products when a speed period completes.
// One item in flight; reset clears the APB registers, counters, pose and sums, speed_period resets to 10.
`default_nettype none
module quadrature_odometry_tracker
    import qot_pkg::*;
#(
    parameter int unsigned CORDIC_ITERATIONS = CordicIterationsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    qot_in_if.sink           in_ch,
    qot_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    // iteration counter covers up to 63 steps
    localparam int unsigned IW = 6;

    state_t state_reg, state_next;

    logic [31:0] rdpc_reg, ldpc_reg, invwb_reg, scale_reg;
    logic [15:0] period_reg;
    logic [31:0] rcnt_reg, lcnt_reg, rprev_reg, lprev_reg;
    logic [63:0] x_reg, y_reg, ctot_reg, rsum_reg, lsum_reg, tsum_reg;
    logic [31:0] head_reg;
    logic [15:0] tick_reg;
    logic [63:0] dr_reg, dl_reg, dc_reg;
    logic signed [63:0] dth_reg;
    logic signed [63:0] cx_reg, cy_reg, cz_reg;
    logic        flip_reg;
    logic [IW-1:0] it_reg;
    logic        valid_q_reg;
    logic        ov_reg;
    logic [63:0] rs_reg, ls_reg, ts_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    qot_serial_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    // APB
    logic wr_en;
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    always_comb
    begin
        unique case (paddr[4:2])
            RegRightDpc:   prdata = rdpc_reg;
            RegLeftDpc:    prdata = ldpc_reg;
            RegInvWb:      prdata = invwb_reg;
            RegSpeedPer:   prdata = {16'd0, period_reg};
            RegSpeedScale: prdata = scale_reg;
            default:       prdata = 32'd0;
        endcase
    end

    // combinational helpers
    logic [63:0] dsub, dsub_raw;
    logic signed [63:0] hsum, hwrap, hfold;
    logic        hflip;
    logic signed [63:0] xs, ys, at;
    logic [15:0] tick_inc, per_eff;
    logic [31:0] dtr, dtl;

    always_comb
    begin
        dsub_raw = dr_reg - dl_reg;
        dsub = dsub_raw;
        if (((dr_reg ^ dl_reg) & (dr_reg ^ dsub_raw) & Sign64) != 64'd0)
        begin
            dsub = dr_reg[63] ? Sign64 : (Sign64 - 64'd1);
        end
        hsum = $signed({{32{head_reg[31]}}, head_reg}) + dth_reg;
        hwrap = hsum;
        if (hsum > PiQ)
        begin
            hwrap = hsum - TwoPiQ;
        end
        else if (hsum < -PiQ)
        begin
            hwrap = hsum + TwoPiQ;
        end
        hfold = hwrap;
        hflip = 1'b0;
        if (hwrap > HalfPiQ)
        begin
            hfold = hwrap - PiQ;
            hflip = 1'b1;
        end
        else if (hwrap < -HalfPiQ)
        begin
            hfold = hwrap + PiQ;
            hflip = 1'b1;
        end
        xs = cx_reg >>> it_reg;
        ys = cy_reg >>> it_reg;
        at = atan_entry(it_reg[4:0]);
        tick_inc = tick_reg + 16'd1;
        per_eff = (period_reg == 16'd0) ? 16'd1 : period_reg;
        dtr = rcnt_reg - rprev_reg;
        dtl = lcnt_reg - lprev_reg;
    end

    // sequencer next state and multiplier requests
    always_comb
    begin
        state_next = state_reg;
        mreq = '0;
        in_ch.ready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.opcode == OpTick)
                begin
                    state_next = ST_MUL_R;
                    mreq.start = 1'b1;
                    mreq.a = {{32{dtr[31]}}, dtr};
                    mreq.b = {1'b0, rdpc_reg};
                end
            end
            ST_MUL_R:
            begin
                if (mrsp.done)
                begin
                    state_next = ST_MUL_L;
                    mreq.start = 1'b1;
                    mreq.a = {{32{dtl[31]}}, dtl};
                    mreq.b = {1'b0, ldpc_reg};
                end
            end
            ST_MUL_L:
            begin
                if (mrsp.done)
                begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                state_next = ST_MUL_TH;
                mreq.start = 1'b1;
                mreq.a = dsub;
                mreq.b = {1'b0, invwb_reg};
                mreq.shift = 6'd27;
            end
            ST_MUL_TH:
            begin
                if (mrsp.done)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (it_reg == IW'(CORDIC_ITERATIONS))
                begin
                    state_next = ST_MUL_X;
                    mreq.start = 1'b1;
                    mreq.a = dc_reg;
                    mreq.b = flip_reg ? 33'(-cx_reg) : cx_reg[32:0];
                    mreq.shift = 6'd30;
                end
            end
            ST_MUL_X:
            begin
                if (mrsp.done)
                begin
                    state_next = ST_MUL_Y;
                    mreq.start = 1'b1;
                    mreq.a = dc_reg;
                    mreq.b = flip_reg ? 33'(-cy_reg) : cy_reg[32:0];
                    mreq.shift = 6'd30;
                end
            end
            ST_MUL_Y:
            begin
                if (mrsp.done)
                begin
                    if (valid_q_reg)
                    begin
                        state_next = ST_MUL_SR;
                        mreq.start = 1'b1;
                        mreq.a = rsum_reg;
                        mreq.b = {1'b0, scale_reg};
                        mreq.shift = 6'd16;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MUL_SR:
            begin
                if (mrsp.done)
                begin
                    state_next = ST_MUL_SL;
                    mreq.start = 1'b1;
                    mreq.a = lsum_reg;
                    mreq.b = {1'b0, scale_reg};
                    mreq.shift = 6'd16;
                end
            end
            ST_MUL_SL:
            begin
                if (mrsp.done)
                begin
                    state_next = ST_MUL_ST;
                    mreq.start = 1'b1;
                    mreq.a = tsum_reg;
                    mreq.b = {1'b0, scale_reg};
                    mreq.shift = 6'd16;
                end
            end
            ST_MUL_ST:
            begin
                if (mrsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdpc_reg <= '0; ldpc_reg <= '0; invwb_reg <= '0; scale_reg <= '0;
            period_reg <= 16'd10;
            rcnt_reg <= '0; lcnt_reg <= '0; rprev_reg <= '0; lprev_reg <= '0;
            x_reg <= '0; y_reg <= '0; ctot_reg <= '0; head_reg <= '0;
            rsum_reg <= '0; lsum_reg <= '0; tsum_reg <= '0; tick_reg <= '0;
            ov_reg <= 1'b0; valid_q_reg <= 1'b0; it_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (paddr[4:2])
                    RegRightDpc:   rdpc_reg <= pwdata;
                    RegLeftDpc:    ldpc_reg <= pwdata;
                    RegInvWb:      invwb_reg <= pwdata;
                    RegSpeedPer:   period_reg <= pwdata[15:0];
                    RegSpeedScale: scale_reg <= pwdata;
                    default: ;
                endcase
            end
            // result valid: set when a pose is loaded, cleared when taken
            if (state_reg == ST_OUT && (!ov_reg || out_ch.ready))
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid && in_ch.opcode == OpEdge)
                    begin
                        if (in_ch.wheel)
                        begin
                            lcnt_reg <= ((in_ch.channel ? (in_ch.level_a == in_ch.level_b)
                                : (in_ch.level_a != in_ch.level_b))) ? lcnt_reg + 32'd1
                                : lcnt_reg - 32'd1;
                        end
                        else
                        begin
                            rcnt_reg <= ((in_ch.channel ? (in_ch.level_a == in_ch.level_b)
                                : (in_ch.level_a != in_ch.level_b))) ? rcnt_reg + 32'd1
                                : rcnt_reg - 32'd1;
                        end
                    end
                    else if (in_ch.valid)
                    begin
                        rprev_reg <= rcnt_reg;
                        valid_q_reg <= (tick_inc >= per_eff);
                        tick_reg <= (tick_inc >= per_eff) ? 16'd0 : tick_inc;
                    end
                end
                ST_MUL_R:
                begin
                    if (mrsp.done)
                    begin
                        dr_reg <= mrsp.result;
                        rsum_reg <= rsum_reg + mrsp.result;
                        lprev_reg <= lcnt_reg;
                    end
                end
                ST_MUL_L:
                begin
                    if (mrsp.done)
                    begin
                        dl_reg <= mrsp.result;
                        lsum_reg <= lsum_reg + mrsp.result;
                    end
                end
                ST_CENTER:
                begin
                    dc_reg <= $unsigned($signed(dr_reg) >>> 1) + $unsigned($signed(dl_reg) >>> 1)
                        + {63'd0, dr_reg[0] & dl_reg[0]};
                end
                ST_MUL_TH:
                begin
                    if (mrsp.done)
                    begin
                        ctot_reg <= ctot_reg + dc_reg;
                        if ($signed(mrsp.result) > 64'sd2147483647)
                        begin
                            dth_reg <= 64'sd2147483647;
                        end
                        else if ($signed(mrsp.result) < -64'sd2147483647)
                        begin
                            dth_reg <= -64'sd2147483647;
                        end
                        else
                        begin
                            dth_reg <= $signed(mrsp.result);
                        end
                    end
                end
                ST_HEAD:
                begin
                    tsum_reg <= tsum_reg + ($unsigned(dth_reg) << 3);
                    head_reg <= hwrap[31:0];
                    cz_reg <= hfold;
                    flip_reg <= hflip;
                    cx_reg <= CordicGain;
                    cy_reg <= '0;
                    it_reg <= '0;
                end
                ST_CORDIC:
                begin
                    if (it_reg != IW'(CORDIC_ITERATIONS))
                    begin
                        it_reg <= it_reg + IW'(1);
                        if (cz_reg >= 0)
                        begin
                            cx_reg <= cx_reg - ys;
                            cy_reg <= cy_reg + xs;
                            cz_reg <= cz_reg - at;
                        end
                        else
                        begin
                            cx_reg <= cx_reg + ys;
                            cy_reg <= cy_reg - xs;
                            cz_reg <= cz_reg + at;
                        end
                    end
                end
                ST_MUL_X:
                begin
                    if (mrsp.done)
                    begin
                        x_reg <= x_reg + mrsp.result;
                    end
                end
                ST_MUL_Y:
                begin
                    if (mrsp.done)
                    begin
                        y_reg <= y_reg + mrsp.result;
                        rs_reg <= '0; ls_reg <= '0; ts_reg <= '0;
                    end
                end
                ST_MUL_SR:
                begin
                    if (mrsp.done)
                    begin
                        rs_reg <= mrsp.result;
                    end
                end
                ST_MUL_SL:
                begin
                    if (mrsp.done)
                    begin
                        ls_reg <= mrsp.result;
                    end
                end
                ST_MUL_ST:
                begin
                    if (mrsp.done)
                    begin
                        ts_reg <= mrsp.result;
                        rsum_reg <= '0; lsum_reg <= '0; tsum_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    logic [63:0] ox_reg, oy_reg, oc_reg, ors_reg, ols_reg, ots_reg;
    logic [31:0] oh_reg;
    logic        osv_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!ov_reg || out_ch.ready))
        begin
            ox_reg <= x_reg; oy_reg <= y_reg; oh_reg <= head_reg; oc_reg <= ctot_reg;
            ors_reg <= rs_reg; ols_reg <= ls_reg; ots_reg <= ts_reg;
            osv_reg <= valid_q_reg;
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.pos_x = ox_reg;
    assign out_ch.pos_y = oy_reg;
    assign out_ch.heading = oh_reg;
    assign out_ch.center_distance = oc_reg;
    assign out_ch.right_speed = ors_reg;
    assign out_ch.left_speed = ols_reg;
    assign out_ch.turn_speed = ots_reg;
    assign out_ch.speed_valid = osv_reg;

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($signed(head_reg) <= 32'sd1686629713) && ($signed(head_reg) >= -32'sd1686629713))
        else $error("heading out of range");
    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
    a_tick_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && valid_q_reg) |-> tick_reg == 16'd0)
        else $error("tick count not cleared");
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mrsp.done) else $error("stray multiplier result");
endmodule
`default_nettype wire

// ===== sv/qot_serial_mul.sv =====
// Bit-serial signed 64x33 multiplier with shift, truncation toward zero and saturation.
// Depends on qot_pkg.
`default_nettype none
module qot_serial_mul
    import qot_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);
    // magnitudes, product accumulates one multiplier bit per cycle
    logic [63:0]  ma_reg;
    logic [31:0]  mb_reg;
    logic [95:0]  acc_reg;
    logic [95:0]  acc_next;
    logic [5:0]   cnt_reg;
    logic         busy_reg;
    logic         neg_reg;
    logic [5:0]   sh_reg;
    logic         done_reg;
    logic [63:0]  res_reg;
    logic [95:0]  shifted;
    logic [63:0]  mag;
    logic         over;
    logic [32:0]  mb_abs;

    // magnitude of the 33-bit signed operand
    always_comb
    begin
        mb_abs = req.b[32] ? (33'd0 - req.b) : req.b;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (mb_reg[cnt_reg[4:0]])
        begin
            acc_next = acc_reg + ({32'd0, ma_reg} << cnt_reg[4:0]);
        end
    end

    // final scaling and saturation
    always_comb
    begin
        shifted = acc_reg >> sh_reg;
        over = (shifted[95:64] != 32'd0) || (shifted[63:0] > Sign64);
        mag = over ? Sign64 : shifted[63:0];
        if (!neg_reg && mag > (Sign64 - 64'd1))
        begin
            mag = Sign64 - 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd32)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg  <= req.a[63] ? (64'd0 - req.a) : req.a;
            mb_reg  <= mb_abs[31:0];
            neg_reg <= req.a[63] ^ req.b[32];
            sh_reg  <= req.shift;
            acc_reg <= '0;
        end
        else if (busy_reg && cnt_reg != 6'd32)
        begin
            acc_reg <= acc_next;
        end
        else if (busy_reg)
        begin
            res_reg <= neg_reg ? (64'd0 - mag) : mag;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("multiplier done held");
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'd32) else $error("bit counter overrun");
endmodule
`default_nettype wire
